@@ hdl/bmts_pkg.sv @@
// ----------------------------------------------------------------------------
// bmts_pkg
// Shared types and constants of the Boyer-Moore text search block.
// ----------------------------------------------------------------------------
package bmts_pkg;

  localparam int unsigned ALPHABET_SIZE = 256;
  localparam int unsigned CHAR_W        = 8;
  // span of the start position field (12 bits)
  localparam int unsigned POS_SPAN      = 4096;

  // command codes carried in the mode field
  localparam logic [1:0] MODE_LOAD_PAT = 2'd0;
  localparam logic [1:0] MODE_LOAD_TXT = 2'd1;
  localparam logic [1:0] MODE_SEARCH   = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] index;
    logic [7:0]  byte_value;
    logic [12:0] text_length;
    logic [11:0] start_pos;
  } in_item_t;

  typedef struct packed {
    logic [12:0] match_position;
    logic        found;
  } out_item_t;

  // operations of the shared position adder
  typedef enum logic [2:0] {
    ALU_INIT  = 3'd0,
    ALU_SKIP  = 3'd1,
    ALU_S_DEC = 3'd2,
    ALU_T_DEC = 3'd3,
    ALU_SHIFT = 3'd4
  } alu_op_e;

  typedef struct packed {
    logic              clear;
    logic              wr_en;
    logic [CHAR_W-1:0] wr_char;
    logic [CHAR_W-1:0] rd_char;
  } tbl_ctl_t;

endpackage

@@ hdl/boyer_moore_text_search.sv @@
// ----------------------------------------------------------------------------
// boyer_moore_text_search
// Tuned Boyer-Moore search over loaded pattern and text stores.
// ----------------------------------------------------------------------------
// Load beats (mode 0 pattern byte, mode 1 text byte) write their store and
// produce no result. A search beat (mode 2) holds in_stall_o high until its
// single result is queued: a start state, a rebuild of the last-occurrence
// table through the pattern store read port, then fast-skip steps (text
// read, table read, position add), a read and a compare per byte verified
// right to left, a shift per mismatch, one more position check when the
// scan runs off the text end, and a final state that queues the result.
// All position arithmetic runs through one shared adder. The result sits
// in an output register, so the next load or search beat is taken while it
// waits; a finished search holds until that register is free. The table
// needs no clearing pass: its per-byte valid bits all clear together at
// each search start.
// ----------------------------------------------------------------------------
module boyer_moore_text_search #(
  parameter int unsigned MAX_PATTERN = 32,
  parameter int unsigned TEXT_DEPTH  = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [5:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bmts_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bmts_pkg::out_item_t out_data_o
);
  import bmts_pkg::*;

  localparam int unsigned PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned TW = $clog2(TEXT_DEPTH);
  localparam int unsigned NW = $clog2(TEXT_DEPTH + 1);
  localparam int unsigned SW = $clog2(TEXT_DEPTH + POS_SPAN + MAX_PATTERN);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_BUILD   = 10'b0000000010,
    ST_SKIP_RD = 10'b0000000100,
    ST_SKIP_TB = 10'b0000001000,
    ST_SKIP_EV = 10'b0000010000,
    ST_VER_RD  = 10'b0000100000,
    ST_VER_CMP = 10'b0001000000,
    ST_VER_SH  = 10'b0010000000,
    ST_DONE    = 10'b0100000000,
    ST_SPARE   = 10'b1000000000
  } state_e;

  state_e            state_q, state_d;
  logic [5:0]        cfg_q;
  logic [LW-1:0]     m_q, m_d, m_cfg;
  logic [NW-1:0]     n_q, n_d, n_in;
  logic [SW-1:0]     s_q, s_d;
  logic [SW-1:0]     t_q, t_d;
  logic [PW-1:0]     i_q, i_d;
  logic [PW-1:0]     j_q, j_d;
  logic              bld_pend_q;
  logic [PW-1:0]     bld_idx_q;
  logic [12:0]       res_pos_q, res_pos_d;
  logic              res_found_q, res_found_d;
  logic              out_valid_q;
  out_item_t         out_data_q;
  logic              out_load;
  logic              in_acc;
  logic              search_go;
  alu_op_e           alu_op;
  logic [SW-1:0]     alu_sum;
  tbl_ctl_t          tbl_ctl;
  logic              tbl_clear;
  logic [LW-1:0]     skip;
  logic              present;
  logic [PW-1:0]     last_idx;
  logic [LW-1:0]     shift;
  logic [PW-1:0]     pat_addr;
  logic [TW-1:0]     txt_addr;
  logic [CHAR_W-1:0] pat_rdata;
  logic [CHAR_W-1:0] txt_rdata;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign search_go   = in_acc && (in_data_i.mode == MODE_SEARCH);

  // clamp the pattern length and the text length into range
  always_comb begin
    if (cfg_q == '0) begin
      m_cfg = LW'(1);
    end else if (32'(cfg_q) > MAX_PATTERN) begin
      m_cfg = LW'(MAX_PATTERN);
    end else begin
      m_cfg = LW'(cfg_q);
    end
    if (32'(in_data_i.text_length) > TEXT_DEPTH) begin
      n_in = NW'(TEXT_DEPTH);
    end else begin
      n_in = NW'(in_data_i.text_length);
    end
  end

  // bad-character shift, at least 1
  always_comb begin
    if (!present) begin
      shift = LW'(j_q) + LW'(1);
    end else if (j_q > last_idx) begin
      shift = LW'(j_q - last_idx);
    end else begin
      shift = LW'(1);
    end
  end

  assign pat_addr = (state_q == ST_BUILD) ? i_q : j_q;
  assign txt_addr = (state_q == ST_VER_RD) ? t_q[TW-1:0] : s_q[TW-1:0];

  assign tbl_ctl.clear   = tbl_clear;
  assign tbl_ctl.wr_en   = bld_pend_q;
  assign tbl_ctl.wr_char = pat_rdata;
  assign tbl_ctl.rd_char = txt_rdata;

  always_comb begin
    state_d     = state_q;
    m_d         = m_q;
    n_d         = n_q;
    s_d         = s_q;
    t_d         = t_q;
    i_d         = i_q;
    j_d         = j_q;
    res_pos_d   = res_pos_q;
    res_found_d = res_found_q;
    alu_op      = ALU_SKIP;
    tbl_clear   = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        alu_op = ALU_INIT;
        if (search_go) begin
          tbl_clear = 1'b1;
          m_d       = m_cfg;
          n_d       = n_in;
          s_d       = alu_sum;
          i_d       = '0;
          state_d   = ST_BUILD;
        end
      end
      ST_BUILD: begin
        if (LW'(i_q) == m_q - LW'(1)) begin
          state_d = ST_SKIP_RD;
        end else begin
          i_d = i_q + PW'(1);
        end
      end
      ST_SKIP_RD: begin
        if (s_q >= SW'(n_q)) begin
          res_pos_d   = 13'(n_q);
          res_found_d = 1'b0;
          state_d     = ST_DONE;
        end else begin
          state_d = ST_SKIP_TB;
        end
      end
      ST_SKIP_TB: begin
        state_d = ST_SKIP_EV;
      end
      ST_SKIP_EV: begin
        if (skip != '0) begin
          alu_op  = ALU_SKIP;
          s_d     = alu_sum;
          state_d = ST_SKIP_RD;
        end else if (m_q == LW'(1)) begin
          res_pos_d   = s_q[12:0];
          res_found_d = 1'b1;
          state_d     = ST_DONE;
        end else begin
          // last byte matches: verify the rest right to left
          alu_op  = ALU_S_DEC;
          t_d     = alu_sum;
          j_d     = PW'(m_q - LW'(2));
          state_d = ST_VER_RD;
        end
      end
      ST_VER_RD: begin
        state_d = ST_VER_CMP;
      end
      ST_VER_CMP: begin
        if (pat_rdata == txt_rdata) begin
          if (j_q == '0) begin
            res_pos_d   = t_q[12:0];
            res_found_d = 1'b1;
            state_d     = ST_DONE;
          end else begin
            alu_op  = ALU_T_DEC;
            t_d     = alu_sum;
            j_d     = j_q - PW'(1);
            state_d = ST_VER_RD;
          end
        end else begin
          // table read of the mismatching byte is under way
          state_d = ST_VER_SH;
        end
      end
      ST_VER_SH: begin
        alu_op  = ALU_SHIFT;
        s_d     = alu_sum;
        state_d = ST_SKIP_RD;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= 6'd1;
      bld_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      bld_pend_q <= (state_q == ST_BUILD);
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_q         <= m_d;
    n_q         <= n_d;
    s_q         <= s_d;
    t_q         <= t_d;
    i_q         <= i_d;
    j_q         <= j_d;
    bld_idx_q   <= i_q;
    res_pos_q   <= res_pos_d;
    res_found_q <= res_found_d;
    if (out_load) begin
      out_data_q.match_position <= res_pos_q;
      out_data_q.found          <= res_found_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  bmts_stores #(
    .MAX_PATTERN (MAX_PATTERN),
    .TEXT_DEPTH  (TEXT_DEPTH),
    .PW          (PW),
    .TW          (TW)
  ) u_stores (
    .clk_i      (clk_i),
    .load_i     (in_acc),
    .item_i     (in_data_i),
    .pat_addr_i (pat_addr),
    .txt_addr_i (txt_addr),
    .pat_data_o (pat_rdata),
    .txt_data_o (txt_rdata)
  );

  bmts_shift_table #(
    .PW (PW),
    .LW (LW)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (tbl_ctl),
    .wr_idx_i  (bld_idx_q),
    .m_i       (m_q),
    .skip_o    (skip),
    .present_o (present),
    .last_o    (last_idx)
  );

  bmts_alu #(
    .SW (SW),
    .LW (LW)
  ) u_alu (
    .op_i        (alu_op),
    .start_pos_i (in_data_i.start_pos),
    .s_i         (s_q),
    .t_i         (t_q),
    .m_i         ((state_q == ST_IDLE) ? m_cfg : m_q),
    .skip_i      (skip),
    .shift_i     (shift),
    .sum_o       (alu_sum)
  );

  // a found match lies wholly inside the text
  a_match_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && res_found_q) |->
      (32'(res_pos_q) + 32'(m_q) <= 32'(n_q)))
    else $error("match runs past the text end");

  // no match reports the effective text length
  a_miss_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !res_found_q) |-> (res_pos_q == 13'(n_q)))
    else $error("miss does not report the text length");

  // verify pointer stays aligned with the window end
  a_ver_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_VER_RD) |->
      (t_q + SW'(m_q) == s_q + SW'(j_q) + SW'(1)))
    else $error("verify pointer out of step");

  // a result beat only follows a finished search
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result raised outside a finished search");

endmodule

@@ hdl/bmts_stores.sv @@
// ----------------------------------------------------------------------------
// bmts_stores
// Pattern and text byte stores: one write port fed by load beats, one
// registered read port each.
// ----------------------------------------------------------------------------
module bmts_stores #(
  parameter int unsigned MAX_PATTERN = 32,
  parameter int unsigned TEXT_DEPTH  = 4096,
  parameter int unsigned PW          = 5,
  parameter int unsigned TW          = 12
) (
  input  logic                     clk_i,
  input  logic                     load_i,
  input  bmts_pkg::in_item_t       item_i,
  input  logic [PW-1:0]            pat_addr_i,
  input  logic [TW-1:0]            txt_addr_i,
  output logic [bmts_pkg::CHAR_W-1:0] pat_data_o,
  output logic [bmts_pkg::CHAR_W-1:0] txt_data_o
);
  import bmts_pkg::*;

  logic [CHAR_W-1:0] pat_mem [MAX_PATTERN];
  logic [CHAR_W-1:0] txt_mem [TEXT_DEPTH];
  logic [CHAR_W-1:0] pat_data_q;
  logic [CHAR_W-1:0] txt_data_q;
  logic              pat_we;
  logic              txt_we;

  // drop loads that fall outside a store
  assign pat_we = load_i && (item_i.mode == MODE_LOAD_PAT) &&
                  (32'(item_i.index) < MAX_PATTERN);
  assign txt_we = load_i && (item_i.mode == MODE_LOAD_TXT) &&
                  (32'(item_i.index) < TEXT_DEPTH);

  always_ff @(posedge clk_i) begin
    if (pat_we) begin
      pat_mem[PW'(item_i.index)] <= item_i.byte_value;
    end
    pat_data_q <= pat_mem[pat_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (txt_we) begin
      txt_mem[TW'(item_i.index)] <= item_i.byte_value;
    end
    txt_data_q <= txt_mem[txt_addr_i];
  end

  assign pat_data_o = pat_data_q;
  assign txt_data_o = txt_data_q;

endmodule

@@ hdl/bmts_shift_table.sv @@
// ----------------------------------------------------------------------------
// bmts_shift_table
// Last-occurrence table over the byte alphabet. Holds the last pattern index
// of each byte; the skip distance is derived from it on read.
// ----------------------------------------------------------------------------
module bmts_shift_table #(
  parameter int unsigned PW = 5,
  parameter int unsigned LW = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bmts_pkg::tbl_ctl_t ctl_i,
  input  logic [PW-1:0]      wr_idx_i,
  input  logic [LW-1:0]      m_i,
  output logic [LW-1:0]      skip_o,
  output logic               present_o,
  output logic [PW-1:0]      last_o
);
  import bmts_pkg::*;

  logic [ALPHABET_SIZE-1:0] vld_q;
  logic [PW-1:0]            last_mem [ALPHABET_SIZE];
  logic [PW-1:0]            last_q;
  logic                     hit_q;

  // one flop per byte value: clear marks every byte absent at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.clear) begin
      vld_q <= '0;
    end else if (ctl_i.wr_en) begin
      vld_q[ctl_i.wr_char] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      last_mem[ctl_i.wr_char] <= wr_idx_i;
    end
    last_q <= last_mem[ctl_i.rd_char];
    hit_q  <= vld_q[ctl_i.rd_char];
  end

  // absent bytes skip a whole pattern length
  assign skip_o    = hit_q ? LW'(m_i - LW'(1) - LW'(last_q)) : m_i;
  assign present_o = hit_q;
  assign last_o    = last_q;

endmodule

@@ hdl/bmts_alu.sv @@
// ----------------------------------------------------------------------------
// bmts_alu
// Shared position adder: every text position update of the search goes
// through this one add/subtract unit.
// ----------------------------------------------------------------------------
module bmts_alu #(
  parameter int unsigned SW = 14,
  parameter int unsigned LW = 6
) (
  input  bmts_pkg::alu_op_e op_i,
  input  logic [11:0]       start_pos_i,
  input  logic [SW-1:0]     s_i,
  input  logic [SW-1:0]     t_i,
  input  logic [LW-1:0]     m_i,
  input  logic [LW-1:0]     skip_i,
  input  logic [LW-1:0]     shift_i,
  output logic [SW-1:0]     sum_o
);
  import bmts_pkg::*;

  logic [SW-1:0] a;
  logic [SW-1:0] b;
  logic          sub;

  always_comb begin
    a   = s_i;
    b   = '0;
    sub = 1'b0;
    case (op_i)
      ALU_INIT: begin
        a = SW'(start_pos_i);
        b = SW'(m_i - LW'(1));
      end
      ALU_SKIP: begin
        b = SW'(skip_i);
      end
      ALU_S_DEC: begin
        b   = SW'(1'b1);
        sub = 1'b1;
      end
      ALU_T_DEC: begin
        a   = t_i;
        b   = SW'(1'b1);
        sub = 1'b1;
      end
      ALU_SHIFT: begin
        b = SW'(shift_i);
      end
      default: begin
        b = '0;
      end
    endcase
  end

  assign sum_o = a + (sub ? ~b : b) + SW'(sub);

endmodule
